FILE: rtl/lmls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmls_pkg
// shared types and constants for the lcd mode and line sequencer
// ----------------------------------------------------------------------------
package lmls_pkg;

    // display modes
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_HBLANK = 2'd0;
    localparam t_mode MODE_VBLANK = 2'd1;
    localparam t_mode MODE_OAM    = 2'd2;
    localparam t_mode MODE_XFER   = 2'd3;

    // mode lengths in machine cycles
    localparam logic [15:0] OAM_CYCLES         = 16'd20;
    localparam logic [15:0] XFER_CYCLES        = 16'd43;
    localparam logic [15:0] HBLANK_CYCLES      = 16'd51;
    localparam logic [15:0] VBLANK_LINE_CYCLES = 16'd114;
    localparam logic [15:0] ACCUM_MAX          = 16'hFFFF;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_LCD_ENABLE     = 3'd0;
    localparam t_cfg_idx CFG_LINE_COMPARE   = 3'd1;
    localparam t_cfg_idx CFG_HBLANK_INT_EN  = 3'd2;
    localparam t_cfg_idx CFG_VBLANK_INT_EN  = 3'd3;
    localparam t_cfg_idx CFG_OAM_INT_EN     = 3'd4;
    localparam t_cfg_idx CFG_MATCH_INT_EN   = 3'd5;

    localparam int CFG_DATA_W = 8;

    typedef struct packed {
        logic       lcd_enable;
        logic [7:0] line_compare;
        logic       hblank_int_enable;
        logic       vblank_int_enable;
        logic       oam_int_enable;
        logic       match_int_enable;
    } t_cfg;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  line;
        logic [15:0] accum;
    } t_state;

    typedef struct packed {
        logic       draw_strobe;
        logic       stat_irq;
        logic       vblank_irq;
        logic       coincidence;
        logic [7:0] line;
        t_mode      mode;
    } t_result;

endpackage

FILE: rtl/lmls_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmls_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
module lmls_cfg_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  lmls_pkg::t_cfg_idx                   i_cfg_index,
    input  logic [lmls_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    output lmls_pkg::t_cfg                       o_cfg
);
    import lmls_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LCD_ENABLE:    n_cfg.lcd_enable        = i_cfg_wdata[0];
                CFG_LINE_COMPARE:  n_cfg.line_compare      = i_cfg_wdata[7:0];
                CFG_HBLANK_INT_EN: n_cfg.hblank_int_enable = i_cfg_wdata[0];
                CFG_VBLANK_INT_EN: n_cfg.vblank_int_enable = i_cfg_wdata[0];
                CFG_OAM_INT_EN:    n_cfg.oam_int_enable    = i_cfg_wdata[0];
                CFG_MATCH_INT_EN:  n_cfg.match_int_enable  = i_cfg_wdata[0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lcd_enable        <= 1'b1;
            r_cfg.line_compare      <= 8'd0;
            r_cfg.hblank_int_enable <= 1'b0;
            r_cfg.vblank_int_enable <= 1'b0;
            r_cfg.oam_int_enable    <= 1'b0;
            r_cfg.match_int_enable  <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/lmls_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmls_step
// one sequencer step: accumulate, test the threshold, at most one transition
// ----------------------------------------------------------------------------
module lmls_step #(
    parameter int VISIBLE_LINES = 144,
    parameter int TOTAL_LINES   = 154
) (
    input  lmls_pkg::t_cfg    i_cfg,
    input  lmls_pkg::t_state  i_state,
    input  logic [7:0]        i_tick,
    output lmls_pkg::t_state  o_state,
    output lmls_pkg::t_result o_result
);
    import lmls_pkg::*;

    localparam logic [7:0] VIS_LINE = 8'(VISIBLE_LINES);
    localparam logic [7:0] TOT_LINE = 8'(TOTAL_LINES);

    logic [16:0] sum;
    logic [15:0] acc;
    logic [15:0] thr;
    logic        hit;
    logic [7:0]  line_inc;
    t_state      nxt;
    t_result     res;

    always_comb begin
        sum      = {1'b0, i_state.accum} + {9'd0, i_tick};
        acc      = sum[16] ? ACCUM_MAX : sum[15:0];
        line_inc = i_state.line + 8'd1;
        case (i_state.mode)
            MODE_HBLANK: thr = HBLANK_CYCLES;
            MODE_VBLANK: thr = VBLANK_LINE_CYCLES;
            MODE_OAM:    thr = OAM_CYCLES;
            MODE_XFER:   thr = XFER_CYCLES;
            default:     thr = XFER_CYCLES;
        endcase
        hit = (acc >= thr);

        nxt = i_state;
        res = '0;

        if (!i_cfg.lcd_enable) begin
            nxt.mode  = MODE_VBLANK;
            nxt.line  = 8'd0;
            nxt.accum = 16'd0;
            res.coincidence = (i_cfg.line_compare == 8'd0);
        end else begin
            nxt.accum = hit ? (acc - thr) : acc;
            if (hit) begin
                case (i_state.mode)
                    MODE_HBLANK: begin
                        nxt.line = line_inc;
                        if (line_inc == VIS_LINE) begin
                            nxt.mode       = MODE_VBLANK;
                            res.vblank_irq = 1'b1;
                            res.stat_irq   = i_cfg.vblank_int_enable;
                        end else begin
                            nxt.mode     = MODE_OAM;
                            res.stat_irq = i_cfg.oam_int_enable;
                        end
                    end
                    MODE_VBLANK: begin
                        if (line_inc == TOT_LINE) begin
                            nxt.line     = 8'd0;
                            nxt.mode     = MODE_OAM;
                            res.stat_irq = i_cfg.oam_int_enable;
                        end else begin
                            nxt.line = line_inc;
                        end
                    end
                    MODE_OAM: begin
                        nxt.mode     = MODE_XFER;
                        res.stat_irq = i_cfg.oam_int_enable;
                    end
                    default: begin
                        nxt.mode        = MODE_HBLANK;
                        res.draw_strobe = 1'b1;
                        res.stat_irq    = i_cfg.hblank_int_enable;
                    end
                endcase
            end
            res.coincidence = (nxt.line == i_cfg.line_compare);
            res.stat_irq    = res.stat_irq | (res.coincidence & i_cfg.match_int_enable);
        end
        res.mode = nxt.mode;
        res.line = nxt.line;
    end

    assign o_state  = nxt;
    assign o_result = res;

endmodule

FILE: rtl/lcd_mode_line_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_mode_line_sequencer
// lcd stat mode and scan line sequencer with vblank and stat interrupt requests
// ----------------------------------------------------------------------------
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata[7:0] tick_cycles
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata[13:0] mode..draw_strobe
//  cfg       in   i_cfg_we (no wait)             i_cfg_index, i_cfg_wdata
//
//  one request per clock sustained while m_axis_tready is high; m_axis_tvalid
//  rises when a held request passes the step logic into the result register
//  the step state (mode, line, cycle counter) lives next to the result register
//  and is updated in the same cycle as the result is loaded
//  synchronous active-low reset: mode oam scan, line 0, counter 0, both
//  pipeline registers empty, configuration to its defaults (display on)
//  a stall on m_axis holds the result register and the input register; the
//  input side then stops taking requests once the input register is full
// ----------------------------------------------------------------------------
module lcd_mode_line_sequencer #(
    parameter int VISIBLE_LINES = 144,
    parameter int TOTAL_LINES   = 154
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  lmls_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [lmls_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [7:0] tick_cycles
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] mode, [9:2] line, [10] coincidence, [11] vblank_irq,
    // [12] stat_irq, [13] draw_strobe, [15:14] zero
    output logic [15:0]                         m_axis_tdata
);
    import lmls_pkg::*;

    t_cfg    cfg;
    t_state  step_state;
    t_result step_result;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_tick;

    // state and result register
    t_state     r_state;
    logic       r_out_valid;
    t_result    r_out;

    logic       out_free;   // result register can take a new value this cycle
    logic       do_step;    // the held request is processed this cycle
    logic       in_take;    // a new request is accepted

    assign out_free      = !r_out_valid || m_axis_tready;
    assign do_step       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    lmls_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    lmls_step #(
        .VISIBLE_LINES (VISIBLE_LINES),
        .TOTAL_LINES   (TOTAL_LINES)
    ) u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_tick   (r_in_tick),
        .o_state  (step_state),
        .o_result (step_result)
    );

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (do_step) begin
            r_in_valid <= 1'b0;
        end
    end

    // tick payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_tick <= s_axis_tdata;
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode  <= MODE_OAM;
            r_state.line  <= 8'd0;
            r_state.accum <= 16'd0;
        end else if (do_step) begin
            r_state <= step_state;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_step) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.draw_strobe, r_out.stat_irq, r_out.vblank_irq,
                            r_out.coincidence, r_out.line, r_out.mode};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // the draw strobe only comes with the switch into hblank
    a_draw_in_hblank : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.draw_strobe) |-> (r_out.mode == MODE_HBLANK))
        else $error("draw strobe outside hblank");

    // a vblank request comes with the first vblank line
    a_vblank_entry : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.vblank_irq) |->
            (r_out.mode == MODE_VBLANK && r_out.line == 8'(VISIBLE_LINES)))
        else $error("vblank request without vblank entry");

    // the result register always mirrors the state it was loaded with
    a_result_tracks_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(do_step) |-> (r_out.mode == r_state.mode && r_out.line == r_state.line))
        else $error("result and sequencer state disagree");

    // input side only stalls when a request is held and the output is blocked
    a_ready_when_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("input stalled without backpressure");

endmodule
